@@ rtl/meot_pkg.sv @@
package meot_pkg;

	localparam int SAMPLE_W  = 24;
	localparam int SEED_W    = 12;
	localparam int OFFSET_W  = 32;
	localparam int CFG_IDX_W = 2;
	localparam int NUM_AXES  = 3;
	localparam int CNT_W     = 4;

	localparam logic [CNT_W-1:0] SYNC_PERIOD = 4'd10;

	localparam logic signed [SAMPLE_W:0]   HALF_RANGE  = 25'sd45000;
	localparam logic signed [SAMPLE_W-1:0] SEED_MARGIN = 24'sd5000;
	localparam logic signed [SAMPLE_W-1:0] SEED_SCALE  = 24'sd1000;
	localparam logic signed [SEED_W:0]     SEED_BIAS   = 13'sd45;

	typedef enum logic [1:0] {
		CMD_SAMPLE = 2'd0,
		CMD_SYNC   = 2'd1,
		CMD_SEED   = 2'd2,
		CMD_NONE   = 2'd3
	} command_t;

	typedef enum logic [1:0] {
		AXIS_X    = 2'd0,
		AXIS_Y    = 2'd1,
		AXIS_Z    = 2'd2,
		AXIS_NONE = 2'd3
	} axis_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SEED_X = 2'd0,
		REG_SEED_Y = 2'd1,
		REG_SEED_Z = 2'd2,
		REG_NONE   = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [1:0]                 command;
		logic [1:0]                 axis;
		logic signed [SAMPLE_W-1:0] sample_value;
	} item_t;

	typedef struct packed {
		logic signed [OFFSET_W-1:0] offset_x;
		logic signed [OFFSET_W-1:0] offset_y;
		logic signed [OFFSET_W-1:0] offset_z;
		logic                       accuracy_flag;
		logic                       updated;
	} result_t;

	typedef struct packed {
		logic sample_en;
		logic sync_fire;
		logic seed_en;
	} axis_ctl_t;

endpackage

@@ rtl/meot_if.sv @@
interface meot_item_if;
	import meot_pkg::*;

	logic  valid;
	logic  ready;
	item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface meot_result_if;
	import meot_pkg::*;

	logic    valid;
	logic    ready;
	result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/meot_axis.sv @@
module meot_axis import meot_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  axis_ctl_t                  ctl,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic signed [SEED_W-1:0]   seed_offset,
	output logic signed [SAMPLE_W-1:0] offset,
	output logic                       changed
);

	logic signed [SAMPLE_W-1:0] min_q;
	logic signed [SAMPLE_W-1:0] max_q;
	logic signed [SAMPLE_W-1:0] off_q;

	logic signed [SEED_W:0]     biased;
	logic signed [SAMPLE_W-1:0] scaled;
	logic signed [SAMPLE_W:0]   lo;
	logic signed [SAMPLE_W:0]   hi;
	logic [SAMPLE_W+1:0]        sum;
	logic [SAMPLE_W+1:0]        adj;
	logic signed [SAMPLE_W-1:0] off_new;
	logic                       min_upd;
	logic                       max_upd;

	// The seed rebuilds a pair of extrema symmetric around zero and loads the offset directly.
	assign biased = $signed({seed_offset[SEED_W-1], seed_offset}) + SEED_BIAS;
	assign scaled = $signed({{(SAMPLE_W-SEED_W-1){biased[SEED_W]}}, biased}) * SEED_SCALE;

	// Halve the sum rounding toward zero: add one before the shift when negative.
	assign lo      = $signed({min_q[SAMPLE_W-1], min_q}) + HALF_RANGE;
	assign hi      = $signed({max_q[SAMPLE_W-1], max_q}) - HALF_RANGE;
	assign sum     = {lo[SAMPLE_W], lo} + {hi[SAMPLE_W], hi};
	assign adj     = sum + {{(SAMPLE_W+1){1'b0}}, sum[SAMPLE_W+1]};
	assign off_new = adj[SAMPLE_W:1];

	assign min_upd = (sample < min_q) || (min_q == '0);
	assign max_upd = (sample > max_q) || (max_q == '0);

	assign changed = ctl.sync_fire && (off_new != off_q);
	assign offset  = off_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= '0;
			max_q <= '0;
			off_q <= '0;
		end else if (ctl.seed_en) begin
			off_q <= $signed({{(SAMPLE_W-SEED_W){seed_offset[SEED_W-1]}}, seed_offset});
			min_q <= SEED_MARGIN - scaled;
			max_q <= scaled - SEED_MARGIN;
		end else if (ctl.sync_fire) begin
			off_q <= off_new;
		end else if (ctl.sample_en) begin
			if (min_upd) begin
				min_q <= sample;
			end
			if (max_upd) begin
				max_q <= sample;
			end
		end
	end

endmodule

@@ rtl/magnetometer_extrema_offset_tracker.sv @@
// An accepted input beat is held in the input register, then moves into the result register;
// it waits in the input register only while an earlier result beat is still stalled.
// Throughput: one beat per cycle while no result beat is stalled; the input register and
// the per-axis update logic feed the result register directly.
// A stalled result holds the input register, which then holds the input side.
// Reset clears the extrema, offsets, sync counter, accuracy bit and seed registers.
module magnetometer_extrema_offset_tracker import meot_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [SEED_W-1:0]    wr_data,
	meot_item_if.sink            item,
	meot_result_if.source        result
);

	logic signed [SEED_W-1:0]   seed_q [NUM_AXES];
	item_t                      item_s1;
	logic                       vld_s1;
	logic                       out_vld_q;
	logic                       updated_q;
	logic                       acc_q;
	logic [CNT_W-1:0]           cnt_q;

	logic                       adv;
	logic                       is_sample;
	logic                       is_sync;
	logic                       is_seed;
	logic                       fire;
	logic [CNT_W-1:0]           cnt_inc;
	logic                       any_changed;
	axis_ctl_t                  ctl [NUM_AXES];
	logic signed [SAMPLE_W-1:0] off [NUM_AXES];
	logic [NUM_AXES-1:0]        changed;

	assign adv        = vld_s1 && (!out_vld_q || result.ready);
	assign item.ready = !vld_s1 || adv;

	assign is_sample = adv && (item_s1.command == CMD_SAMPLE);
	assign is_sync   = adv && (item_s1.command == CMD_SYNC);
	assign is_seed   = adv && (item_s1.command == CMD_SEED);
	assign cnt_inc   = cnt_q + CNT_W'(1);
	assign fire      = is_sync && (cnt_inc >= SYNC_PERIOD);

	assign any_changed = |changed;

	for (genvar i = 0; i < NUM_AXES; i++) begin : g_axis
		assign ctl[i].sample_en = is_sample && (item_s1.axis == 2'(i))
			&& (item_s1.sample_value != '0);
		assign ctl[i].sync_fire = fire;
		assign ctl[i].seed_en   = is_seed;

		meot_axis u_axis (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl[i]),
			.sample      (item_s1.sample_value),
			.seed_offset (seed_q[i]),
			.offset      (off[i]),
			.changed     (changed[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				seed_q[i] <= '0;
			end
		end else if (wr_en) begin
			unique case (cfg_reg_t'(wr_index))
				REG_SEED_X: seed_q[AXIS_X] <= wr_data;
				REG_SEED_Y: seed_q[AXIS_Y] <= wr_data;
				REG_SEED_Z: seed_q[AXIS_Z] <= wr_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (item.ready) begin
			vld_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			item_s1 <= item.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			updated_q <= 1'b0;
			acc_q     <= 1'b0;
			cnt_q     <= '0;
		end else begin
			if (adv) begin
				out_vld_q <= 1'b1;
				updated_q <= any_changed;
			end else if (result.ready) begin
				out_vld_q <= 1'b0;
			end
			if (is_sync) begin
				cnt_q <= fire ? '0 : cnt_inc;
			end
			if (is_seed || any_changed) begin
				acc_q <= 1'b1;
			end
		end
	end

	// The state only moves while no earlier result beat is waiting, so it is the result payload.
	assign result.valid              = out_vld_q;
	assign result.data.offset_x      = {{(OFFSET_W-SAMPLE_W){off[AXIS_X][SAMPLE_W-1]}}, off[AXIS_X]};
	assign result.data.offset_y      = {{(OFFSET_W-SAMPLE_W){off[AXIS_Y][SAMPLE_W-1]}}, off[AXIS_Y]};
	assign result.data.offset_z      = {{(OFFSET_W-SAMPLE_W){off[AXIS_Z][SAMPLE_W-1]}}, off[AXIS_Z]};
	assign result.data.accuracy_flag = acc_q;
	assign result.data.updated       = updated_q;

	a_updated_acc: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.data.updated |-> result.data.accuracy_flag)
		else $error("updated result without accuracy flag");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q < SYNC_PERIOD)
		else $error("sync counter out of range");

	a_acc_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		acc_q |=> acc_q)
		else $error("accuracy bit cleared");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && !result.ready |=> $stable(off[AXIS_X]) && $stable(off[AXIS_Y])
			&& $stable(off[AXIS_Z]) && $stable(acc_q))
		else $error("state moved under a stalled result");

endmodule
